// ===== src/rsch_pkg.sv =====
package rsch_pkg;

  localparam int MAX_SPHERES_DEF = 64;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int LIMB_W     = 32;
  localparam int LIMB_IDX_W = 3;
  localparam int QBITS_W    = 6;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic                    start;
    logic [1:0]              op;
    logic [LIMB_IDX_W-1:0]   a_last;
    logic [LIMB_IDX_W-1:0]   b_last;
    logic [QBITS_W-1:0]      qbits;
  } mu_ctrl_t;

  function automatic int limbs(input int bits);
    return (bits + LIMB_W - 1) / LIMB_W;
  endfunction

endpackage

// ===== src/rsch_table.sv =====
module rsch_table #(
  parameter int DEPTH = rsch_pkg::MAX_SPHERES_DEF,
  parameter int AW    = 6,
  parameter int TW    = 4 * rsch_pkg::COORD_WIDTH_DEF + 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [TW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [TW-1:0] rdata
);

  logic [TW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rsch_mathu.sv =====
module rsch_mathu #(
  parameter int WW = 4 * rsch_pkg::COORD_WIDTH_DEF + 8,
  parameter int RB = 2 * rsch_pkg::COORD_WIDTH_DEF + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rsch_pkg::mu_ctrl_t      ctrl,
  input  logic signed [WW-1:0]    a,
  input  logic signed [WW-1:0]    b,
  output logic                    done,
  output logic signed [WW-1:0]    res
);

  localparam int NL = rsch_pkg::limbs(WW);
  localparam int PW = NL * rsch_pkg::LIMB_W;
  localparam int LW = rsch_pkg::LIMB_W;
  localparam int IW = rsch_pkg::LIMB_IDX_W;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_ADD  = 3'd2;
  localparam logic [2:0] P_FIN  = 3'd3;
  localparam logic [2:0] P_DCHK = 3'd4;
  localparam logic [2:0] P_DIV  = 3'd5;
  localparam logic [2:0] P_SQ   = 3'd6;

  logic [2:0]    phase;
  logic [1:0]    op;
  logic [PW-1:0] ma, mb, acc, rem, ds;
  logic          neg;
  logic [IW-1:0] ia, ib, a_last, b_last;
  logic [63:0]   pp;
  logic [IW:0]   ppos;
  logic          ppv;
  logic [6:0]    cnt;
  logic [31:0]   q;

  logic [WW-1:0] a_abs, b_abs;
  logic [LW-1:0] limb_a, limb_b;
  logic [PW-1:0] trial;
  logic [31:0]   cap;

  assign a_abs  = a[WW-1] ? WW'(-a) : WW'(a);
  assign b_abs  = b[WW-1] ? WW'(-b) : WW'(b);
  assign limb_a = ma[ia*LW +: LW];
  assign limb_b = mb[ib*LW +: LW];
  assign trial  = acc | ds;
  assign cap    = 32'hFFFF_FFFF >> (6'd32 - ctrl.qbits);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    ppv  <= (phase == P_MUL);
    if (ppv) begin
      acc <= acc + (PW'(pp) << {ppos, 5'b0});
    end
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      ppv   <= 1'b0;
    end else begin
      case (phase)
        P_IDLE: begin
          if (ctrl.start) begin
            op     <= ctrl.op;
            ma     <= PW'(a_abs);
            mb     <= PW'(b_abs);
            neg    <= a[WW-1] ^ b[WW-1];
            ia     <= '0;
            ib     <= '0;
            a_last <= ctrl.a_last;
            b_last <= ctrl.b_last;
            q      <= '0;
            case (ctrl.op)
              rsch_pkg::OP_MUL: begin
                acc   <= '0;
                phase <= P_MUL;
              end
              rsch_pkg::OP_DIV: begin
                rem   <= PW'(a_abs);
                ds    <= PW'(b_abs) << ctrl.qbits;
                cnt   <= 7'(ctrl.qbits);
                phase <= P_DCHK;
              end
              default: begin
                rem   <= PW'(a_abs);
                acc   <= '0;
                ds    <= PW'(1) << (2 * (RB - 1));
                cnt   <= 7'(RB);
                phase <= P_SQ;
              end
            endcase
          end
        end
        P_MUL: begin
          pp   <= 64'(limb_a) * 64'(limb_b);
          ppos <= (IW+1)'(ia) + (IW+1)'(ib);
          if (ib == b_last) begin
            ib <= '0;
            if (ia == a_last) begin
              phase <= P_ADD;
            end else begin
              ia <= ia + 1'b1;
            end
          end else begin
            ib <= ib + 1'b1;
          end
        end
        P_ADD: begin
          phase <= P_FIN;
        end
        P_DCHK: begin
          if (rem >= ds) begin
            q     <= cap;
            phase <= P_FIN;
          end else begin
            ds    <= ds >> 1;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          if (rem >= ds) begin
            rem <= rem - ds;
          end
          q   <= {q[30:0], (rem >= ds)};
          ds  <= ds >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == 7'd1) begin
            phase <= P_FIN;
          end
        end
        P_SQ: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            acc <= (acc >> 1) | ds;
          end else begin
            acc <= acc >> 1;
          end
          ds  <= ds >> 2;
          cnt <= cnt - 1'b1;
          if (cnt == 7'd1) begin
            phase <= P_FIN;
          end
        end
        P_FIN: begin
          case (op)
            rsch_pkg::OP_MUL: res <= neg ? -WW'(acc) : WW'(acc);
            rsch_pkg::OP_DIV: res <= WW'(q);
            default:          res <= WW'(acc);
          endcase
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ray_sphere_closest_hit_core.sv =====
// Ray / sphere closest-hit core.
// Input stream (s_*): one word per item. s_tuser[0] = 0 loads a sphere into
// slot entry_index (no result); s_tuser[0] = 1 is a ray
// query that always yields exactly one result word on the m_* stream.
// Per query: for each tested sphere of non-zero radius, 9 limb-serial
// multiplies, then, if the discriminant is not negative, a square root and
// one or two divisions; after the walk, the point and normal are formed for
// the closest hit. All of it runs through the single shared arithmetic unit,
// one query at a time; s_tready is low while a query is in flight.
// sphere_count (APB, byte address 0) sets how many slots a query walks.
// Reset clears sphere_count and the control state; the sphere table is not
// cleared, so slots must be loaded before a query reaches them.
// A finished result sits in the output register until m_tready; a further
// query may be accepted meanwhile, and holds at its end until the register
// frees up.
module ray_sphere_closest_hit_core #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF,
  parameter int COORD_WIDTH = rsch_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // entry_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, radius, material,
  // t_min, t_max
  input  logic [((7*COORD_WIDTH+77+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z,
  // front_face, hit_material
  output logic [((3*COORD_WIDTH+95+7)/8)*8-1:0] m_tdata,
  // hit
  output logic [0:0]           m_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int W   = COORD_WIDTH;
  localparam int WW  = 4 * W + 8;
  localparam int RB  = 2 * W + 4;
  localparam int AW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW  = $clog2(MAX_SPHERES + 1);
  localparam int TW  = 4 * W + 7;
  localparam int OTW = ((3 * W + 95 + 7) / 8) * 8;

  localparam int O_PX = 6;
  localparam int O_PY = 6 + W;
  localparam int O_PZ = 6 + 2 * W;
  localparam int O_DX = 6 + 3 * W;
  localparam int O_DY = 6 + 4 * W;
  localparam int O_DZ = 6 + 5 * W;
  localparam int O_R  = 6 + 6 * W;
  localparam int O_M  = 5 + 7 * W;
  localparam int O_T0 = 13 + 7 * W;
  localparam int O_T1 = 45 + 7 * W;

  localparam int NB_N = (W + 2 > 33) ? W + 2 : 33;
  localparam logic [2:0] LN = 3'(rsch_pkg::limbs(NB_N) - 1);
  localparam logic [2:0] LH = 3'(rsch_pkg::limbs(2 * W + 4) - 1);

  localparam logic signed [WW-1:0] P_HI = {{(WW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [WW-1:0] P_LO = ~P_HI;

  localparam logic REG_SPHERE_COUNT = 1'b0;
  localparam logic KIND_LOAD = 1'b0;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_A    = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_RW   = 5'd3;
  localparam logic [4:0] S_RR   = 5'd4;
  localparam logic [4:0] S_HB   = 5'd5;
  localparam logic [4:0] S_CC   = 5'd6;
  localparam logic [4:0] S_D1   = 5'd7;
  localparam logic [4:0] S_D2   = 5'd8;
  localparam logic [4:0] S_SQ   = 5'd9;
  localparam logic [4:0] S_R0   = 5'd10;
  localparam logic [4:0] S_R1   = 5'd11;
  localparam logic [4:0] S_FIN  = 5'd12;
  localparam logic [4:0] S_FR   = 5'd13;
  localparam logic [4:0] S_P    = 5'd14;
  localparam logic [4:0] S_PS   = 5'd15;
  localparam logic [4:0] S_PD   = 5'd16;
  localparam logic [4:0] S_DT   = 5'd17;
  localparam logic [4:0] S_N    = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  // input fields
  logic        [5:0]   in_idx;
  logic signed [W-1:0] in_p [3];
  logic signed [W-1:0] in_d [3];
  logic        [W-2:0] in_r;
  logic        [7:0]   in_m;
  logic signed [31:0]  in_t0, in_t1;

  assign in_idx  = s_tdata[5:0];
  assign in_p[0] = s_tdata[O_PX +: W];
  assign in_p[1] = s_tdata[O_PY +: W];
  assign in_p[2] = s_tdata[O_PZ +: W];
  assign in_d[0] = s_tdata[O_DX +: W];
  assign in_d[1] = s_tdata[O_DY +: W];
  assign in_d[2] = s_tdata[O_DZ +: W];
  assign in_r    = s_tdata[O_R +: W-1];
  assign in_m    = s_tdata[O_M +: 8];
  assign in_t0   = s_tdata[O_T0 +: 32];
  assign in_t1   = s_tdata[O_T1 +: 32];

  // config
  logic [6:0] sphere_count;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPHERE_COUNT) ? 32'(sphere_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= 7'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SPHERE_COUNT) begin
      sphere_count <= pwdata[6:0];
    end
  end

  // state
  logic [4:0]             state;
  logic [1:0]             kk;
  logic                   issued, found, sel;
  logic signed [W-1:0]    org [3];
  logic signed [W-1:0]    dir [3];
  logic signed [W-1:0]    cen [3];
  logic signed [W-1:0]    pnt [3];
  logic signed [W:0]      dd  [3];
  logic signed [17:0]     nrm [3];
  logic        [W-2:0]    rad;
  logic        [7:0]      mat;
  logic signed [31:0]     tmin, best;
  logic signed [WW-1:0]   a_r, hb, cc, disc, sd, num, dot, pw;
  logic        [CW-1:0]   i_r, lim;
  logic        [AW-1:0]   idx;

  // output register
  logic                   ov, out_hit, out_ff;
  logic signed [31:0]     out_t;
  logic signed [W-1:0]    out_p [3];
  logic signed [17:0]     out_n [3];
  logic        [7:0]      out_mat;

  // table
  logic          tbl_we, tbl_re;
  logic [AW-1:0] tbl_raddr;
  logic [TW-1:0] tbl_rdata;

  assign s_tready = (state == S_IDLE);
  assign tbl_we   = s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD) &&
                    (32'(in_idx) < MAX_SPHERES);

  rsch_table #(.DEPTH(MAX_SPHERES), .AW(AW), .TW(TW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_idx)),
    .wdata ({in_m, in_r, in_p[2], in_p[1], in_p[0]}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // arithmetic unit
  rsch_pkg::mu_ctrl_t   ctl;
  logic signed [WW-1:0] mu_a, mu_b, mu_res;
  logic                 mu_done;

  rsch_mathu #(.WW(WW), .RB(RB)) u_mathu (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctl),
    .a    (mu_a),
    .b    (mu_b),
    .done (mu_done),
    .res  (mu_res)
  );

  logic signed [W:0]    oc;
  logic signed [WW-1:0] disc_n, fl;
  logic        [31:0]   q32;
  logic signed [31:0]   t_root;
  logic        [17:0]   q18, qc;
  logic signed [17:0]   nv;
  logic        [CW-1:0] cnt_lim;
  logic signed [W-1:0]  p_sat;

  assign oc      = {org[kk][W-1], org[kk]} - {cen[kk][W-1], cen[kk]};
  assign disc_n  = disc - mu_res;
  assign q32     = mu_res[31:0];
  assign t_root  = num[WW-1] ?
                   ((q32 > 32'h8000_0000) ? 32'sh8000_0000 : -q32) :
                   ((q32 > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q32);
  assign q18     = mu_res[17:0];
  assign qc      = (q18 > 18'd65536) ? 18'd65536 : q18;
  assign nv      = (dd[kk][W] ^ ~dot[WW-1]) ? -qc : qc;
  assign cnt_lim = (32'(sphere_count) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(sphere_count);
  assign fl      = pw >>> 16;
  assign p_sat   = (fl > P_HI) ? P_HI[W-1:0] : (fl < P_LO) ? P_LO[W-1:0] : fl[W-1:0];

  always_comb begin
    ctl.start  = 1'b0;
    ctl.op     = rsch_pkg::OP_MUL;
    ctl.a_last = LN;
    ctl.b_last = LN;
    ctl.qbits  = '0;
    mu_a       = '0;
    mu_b       = '0;
    tbl_re     = 1'b0;
    tbl_raddr  = i_r[AW-1:0];
    case (state)
      S_A: begin
        ctl.start = !issued;
        mu_a = WW'(dir[kk]);
        mu_b = WW'(dir[kk]);
      end
      S_RD: begin
        tbl_re = (i_r != lim);
      end
      S_RR: begin
        ctl.start = !issued;
        mu_a = WW'(rad);
        mu_b = WW'(rad);
      end
      S_HB: begin
        ctl.start = !issued;
        mu_a = WW'(oc);
        mu_b = WW'(dir[kk]);
      end
      S_CC: begin
        ctl.start = !issued;
        mu_a = WW'(oc);
        mu_b = WW'(oc);
      end
      S_D1: begin
        ctl.start  = !issued;
        ctl.a_last = LH;
        ctl.b_last = LH;
        mu_a = hb;
        mu_b = hb;
      end
      S_D2: begin
        ctl.start  = !issued;
        ctl.a_last = LH;
        ctl.b_last = LH;
        mu_a = a_r;
        mu_b = cc;
      end
      S_SQ: begin
        ctl.start = !issued;
        ctl.op    = rsch_pkg::OP_SQRT;
        mu_a = disc;
      end
      S_R1: begin
        ctl.start = !issued;
        ctl.op    = rsch_pkg::OP_DIV;
        ctl.qbits = 6'd32;
        mu_a = num <<< 16;
        mu_b = a_r;
      end
      S_FIN: begin
        tbl_re    = found;
        tbl_raddr = idx;
      end
      S_P: begin
        ctl.start = !issued;
        mu_a = WW'(best);
        mu_b = WW'(dir[kk]);
      end
      S_DT: begin
        ctl.start = !issued;
        mu_a = WW'(dir[kk]);
        mu_b = WW'(dd[kk]);
      end
      S_N: begin
        ctl.start = !issued;
        ctl.op    = rsch_pkg::OP_DIV;
        ctl.qbits = 6'd18;
        mu_a = WW'(dd[kk]) <<< 16;
        mu_b = WW'(rad);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      found  <= 1'b0;
    end else begin
      if (ctl.start) begin
        issued <= 1'b1;
      end
      if (mu_done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser[0] != KIND_LOAD) begin
            for (int k = 0; k < 3; k++) begin
              org[k] <= in_p[k];
              dir[k] <= in_d[k];
            end
            tmin  <= in_t0;
            best  <= in_t1;
            found <= 1'b0;
            a_r   <= '0;
            kk    <= '0;
            i_r   <= '0;
            lim   <= cnt_lim;
            if (in_d[0] == '0 && in_d[1] == '0 && in_d[2] == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_A;
            end
          end
        end
        S_A: begin
          if (mu_done) begin
            a_r <= a_r + mu_res;
            if (kk == 2'd2) begin
              kk    <= '0;
              state <= S_RD;
            end else begin
              kk <= kk + 1'b1;
            end
          end
        end
        S_RD: begin
          state <= (i_r == lim) ? S_FIN : S_RW;
        end
        S_RW: begin
          cen[0] <= tbl_rdata[W-1:0];
          cen[1] <= tbl_rdata[2*W-1:W];
          cen[2] <= tbl_rdata[3*W-1:2*W];
          rad    <= tbl_rdata[4*W-2:3*W];
          mat    <= tbl_rdata[4*W+6:4*W-1];
          hb     <= '0;
          kk     <= '0;
          if (tbl_rdata[4*W-2:3*W] == '0) begin
            i_r   <= i_r + 1'b1;
            state <= S_RD;
          end else begin
            state <= S_RR;
          end
        end
        S_RR: begin
          if (mu_done) begin
            cc    <= -mu_res;
            state <= S_HB;
          end
        end
        S_HB: begin
          if (mu_done) begin
            hb    <= hb + mu_res;
            state <= S_CC;
          end
        end
        S_CC: begin
          if (mu_done) begin
            cc <= cc + mu_res;
            if (kk == 2'd2) begin
              kk    <= '0;
              state <= S_D1;
            end else begin
              kk    <= kk + 1'b1;
              state <= S_HB;
            end
          end
        end
        S_D1: begin
          if (mu_done) begin
            disc  <= mu_res;
            state <= S_D2;
          end
        end
        S_D2: begin
          if (mu_done) begin
            disc <= disc_n;
            if (disc_n[WW-1]) begin
              i_r   <= i_r + 1'b1;
              state <= S_RD;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (mu_done) begin
            sd    <= mu_res;
            sel   <= 1'b0;
            state <= S_R0;
          end
        end
        S_R0: begin
          num   <= sel ? (sd - hb) : (~hb - sd + WW'(1));
          state <= S_R1;
        end
        S_R1: begin
          if (mu_done) begin
            if (tmin < t_root && t_root < best) begin
              best  <= t_root;
              found <= 1'b1;
              idx   <= i_r[AW-1:0];
              i_r   <= i_r + 1'b1;
              state <= S_RD;
            end else if (!sel) begin
              sel   <= 1'b1;
              state <= S_R0;
            end else begin
              i_r   <= i_r + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          kk    <= '0;
          dot   <= '0;
          state <= found ? S_FR : S_DONE;
        end
        S_FR: begin
          cen[0] <= tbl_rdata[W-1:0];
          cen[1] <= tbl_rdata[2*W-1:W];
          cen[2] <= tbl_rdata[3*W-1:2*W];
          rad    <= tbl_rdata[4*W-2:3*W];
          mat    <= tbl_rdata[4*W+6:4*W-1];
          state  <= S_P;
        end
        S_P: begin
          if (mu_done) begin
            pw    <= (WW'(org[kk]) <<< 16) + mu_res;
            state <= S_PS;
          end
        end
        S_PS: begin
          pnt[kk] <= p_sat;
          state   <= S_PD;
        end
        S_PD: begin
          dd[kk] <= {pnt[kk][W-1], pnt[kk]} - {cen[kk][W-1], cen[kk]};
          state  <= S_DT;
        end
        S_DT: begin
          if (mu_done) begin
            dot <= dot + mu_res;
            if (kk == 2'd2) begin
              kk    <= '0;
              state <= S_N;
            end else begin
              kk    <= kk + 1'b1;
              state <= S_P;
            end
          end
        end
        S_N: begin
          if (mu_done) begin
            nrm[kk] <= nv;
            if (kk == 2'd2) begin
              state <= S_DONE;
            end else begin
              kk <= kk + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!ov || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_DONE && (!ov || m_tready)) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!ov || m_tready)) begin
      out_hit <= found;
      out_t   <= found ? best : 32'sd0;
      out_ff  <= found & dot[WW-1];
      out_mat <= found ? mat : 8'd0;
      for (int k = 0; k < 3; k++) begin
        out_p[k] <= found ? pnt[k] : '0;
        out_n[k] <= found ? nrm[k] : '0;
      end
    end
  end

  assign m_tvalid   = ov;
  assign m_tuser[0] = out_hit;
  assign m_tdata    = OTW'({out_mat, out_ff, out_n[2], out_n[1], out_n[0],
                            out_p[2], out_p[1], out_p[0], out_t});

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == S_IDLE)
    else $error("table written during a query");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    ov && !out_hit |-> out_t == 32'sd0 && out_mat == 8'd0 && !out_ff)
    else $error("miss word carries data");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && ov && !m_tready |=> state == S_DONE)
    else $error("result dropped while output stalled");

  a_mu_req: assert property (@(posedge clk) disable iff (rst)
    mu_done |-> issued)
    else $error("arithmetic result without request");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    ov |-> out_n[0] <= 18'sd65536 && out_n[0] >= -18'sd65536)
    else $error("normal out of range");

endmodule

// ===== verif/ray_sphere_closest_hit_core_tb.sv =====
module ray_sphere_closest_hit_core_tb;

  localparam int U = 65536;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [2:0] ADDR_SPHERE_COUNT = 3'd0;
  localparam int NSLOT = rsch_pkg::MAX_SPHERES_DEF;
  localparam int HOLD_CYCLES = 2000;
  localparam int TARGET_WORDS = 1500;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [63:0] s64_t;

  typedef struct {
    logic kind;
    logic [5:0] idx;
    logic signed [31:0] pos[3];
    logic signed [31:0] dir[3];
    logic [30:0] radius;
    logic [7:0] mat;
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
  } item_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] t;
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic front;
    logic [7:0] mat;
  } hit_res_t;

  typedef enum logic [1:0] {ST_LOAD, ST_QUERY, ST_CFG} step_op_t;

  typedef struct {
    step_op_t op;
    item_t it;
    logic [6:0] cfg;
    bit known_miss;
  } step_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [303:0] s_tdata;
  logic [0:0] s_tuser, m_tuser;
  logic [191:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  s64_t tab_cen[NSLOT][3];
  s64_t tab_rad[NSLOT];
  logic [7:0] tab_mat[NSLOT];
  logic [6:0] sphere_cnt;

  hit_res_t pending_hits[$];
  step_t steps[$];
  int mismatches;
  int words_sent;
  bit quiet;
  bit hold_req;

  ray_sphere_closest_hit_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic s64_t sat32(wide_t v);
    if (v > wide_t'(64'sh7FFFFFFF)) return 64'sh7FFFFFFF;
    if (v < -wide_t'(64'sh80000000)) return -64'sh80000000;
    return s64_t'(v);
  endfunction

  function automatic wide_t floor_sqrt(wide_t v);
    wide_t r, c;
    r = '0;
    for (int k = 67; k >= 0; k--) begin
      c = r;
      c[k] = 1'b1;
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic s64_t root_at(wide_t num, wide_t a);
    bit neg;
    wide_t mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag * 65536) / a;
    if (q > wide_t'(64'shFFFFFFFF)) q = wide_t'(64'shFFFFFFFF);
    return sat32(neg ? -q : q);
  endfunction

  function automatic hit_res_t trace_ray(item_t q);
    wide_t a, hb, c, disc, sd, oc, pw, dotv, mag, qv, nv;
    s64_t org[3], dir[3], cen[3], p[3], d[3];
    s64_t best, tmin, t;
    int n, idx;
    bit found, front, neg;
    logic signed [17:0] nrm[3];
    hit_res_t r;
    r = '0;
    found = 0;
    idx = 0;
    for (int k = 0; k < 3; k++) begin
      org[k] = q.pos[k];
      dir[k] = q.dir[k];
    end
    tmin = q.tmin;
    best = q.tmax;
    if (dir[0] == 0 && dir[1] == 0 && dir[2] == 0) return r;
    a = '0;
    for (int k = 0; k < 3; k++) a += wide_t'(dir[k]) * wide_t'(dir[k]);
    n = sphere_cnt > NSLOT ? NSLOT : sphere_cnt;
    for (int i = 0; i < n; i++) begin
      if (tab_rad[i] == 0) continue;
      c = -(wide_t'(tab_rad[i]) * wide_t'(tab_rad[i]));
      hb = '0;
      for (int k = 0; k < 3; k++) begin
        oc = wide_t'(org[k]) - wide_t'(tab_cen[i][k]);
        hb += oc * wide_t'(dir[k]);
        c += oc * oc;
      end
      disc = hb * hb - a * c;
      if (disc < 0) continue;
      sd = floor_sqrt(disc);
      t = root_at(-hb - sd, a);
      if (!(tmin < t && t < best)) begin
        t = root_at(-hb + sd, a);
        if (!(tmin < t && t < best)) continue;
      end
      best = t;
      found = 1;
      idx = i;
    end
    if (!found) return r;
    dotv = '0;
    for (int k = 0; k < 3; k++) begin
      cen[k] = tab_cen[idx][k];
      pw = wide_t'(org[k]) * 65536 + wide_t'(best) * wide_t'(dir[k]);
      p[k] = sat32(pw >>> 16);
      d[k] = p[k] - cen[k];
      dotv += wide_t'(dir[k]) * wide_t'(d[k]);
    end
    front = dotv < 0;
    for (int k = 0; k < 3; k++) begin
      neg = d[k] < 0;
      mag = neg ? -wide_t'(d[k]) : wide_t'(d[k]);
      qv = (mag * 65536) / wide_t'(tab_rad[idx]);
      if (qv > 65536) qv = 65536;
      nv = neg ? -qv : qv;
      if (!front) nv = -nv;
      nrm[k] = nv[17:0];
    end
    r.hit = 1'b1;
    r.t = best[31:0];
    r.px = p[0][31:0];
    r.py = p[1][31:0];
    r.pz = p[2][31:0];
    r.nx = nrm[0];
    r.ny = nrm[1];
    r.nz = nrm[2];
    r.front = front;
    r.mat = tab_mat[idx];
    return r;
  endfunction

  function automatic logic [303:0] pack_item(item_t it);
    return {3'b0, it.tmax, it.tmin, it.mat, it.radius, it.dir[2], it.dir[1], it.dir[0],
            it.pos[2], it.pos[1], it.pos[0], it.idx};
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", field, got, want);
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(field, got, want);
  endtask

  always @(posedge clk) begin
    hit_res_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.hit = m_tuser[0];
      got.t = m_tdata[31:0];
      got.px = m_tdata[63:32];
      got.py = m_tdata[95:64];
      got.pz = m_tdata[127:96];
      got.nx = m_tdata[145:128];
      got.ny = m_tdata[163:146];
      got.nz = m_tdata[181:164];
      got.front = m_tdata[182];
      got.mat = m_tdata[190:183];
      if (pending_hits.size() == 0) begin
        report("unexpected word", m_tdata[63:0], 64'h0);
      end else begin
        want = pending_hits.pop_front();
        check_field("hit", got.hit, want.hit);
        check_field("hit_t", got.t, want.t);
        check_field("point_x", got.px, want.px);
        check_field("point_y", got.py, want.py);
        check_field("point_z", got.pz, want.pz);
        check_field("normal_x", got.nx, want.nx);
        check_field("normal_y", got.ny, want.ny);
        check_field("normal_z", got.nz, want.nz);
        check_field("front_face", got.front, want.front);
        check_field("hit_material", got.mat, want.mat);
      end
    end
  end

  // sink: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 0;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send(item_t it, bit known_miss);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= pack_item(it);
    s_tuser <= it.kind;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (it.kind == KIND_LOAD) begin
      for (int k = 0; k < 3; k++) tab_cen[it.idx][k] = it.pos[k];
      tab_rad[it.idx] = s64_t'({1'b0, it.radius});
      tab_mat[it.idx] = it.mat;
    end else begin
      pending_hits.push_back(known_miss ? hit_res_t'('0) : trace_ray(it));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [6:0] val);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SPHERE_COUNT;
    pwdata <= {25'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sphere_cnt = val;
  endtask

  function automatic item_t mk(logic kind, int idx, int px, int py, int pz, int dx, int dy,
                               int dz, int rad, int mat, int tmin, int tmax);
    item_t it;
    it.kind = kind;
    it.idx = idx[5:0];
    it.pos[0] = px;
    it.pos[1] = py;
    it.pos[2] = pz;
    it.dir[0] = dx;
    it.dir[1] = dy;
    it.dir[2] = dz;
    it.radius = rad[30:0];
    it.mat = mat[7:0];
    it.tmin = tmin;
    it.tmax = tmax;
    return it;
  endfunction

  task automatic add_step(step_op_t op, item_t it, int cfg, bit known_miss);
    step_t s;
    s.op = op;
    s.it = it;
    s.cfg = cfg[6:0];
    s.known_miss = known_miss;
    steps.push_back(s);
  endtask

  function automatic item_t noise_item(logic kind);
    item_t it;
    it.kind = kind;
    it.idx = $urandom;
    for (int k = 0; k < 3; k++) begin
      it.pos[k] = $urandom;
      it.dir[k] = $urandom;
    end
    it.radius = $urandom;
    it.mat = $urandom;
    it.tmin = $urandom;
    it.tmax = $urandom;
    return it;
  endfunction

  function automatic item_t good_sphere(int slot);
    item_t it;
    it = noise_item(KIND_LOAD);
    it.idx = slot[5:0];
    for (int k = 0; k < 3; k++) it.pos[k] = $urandom_range(0, 60 * U) - 30 * U;
    it.radius = $urandom_range(U / 4, 8 * U);
    return it;
  endfunction

  function automatic item_t aimed_ray();
    item_t it;
    int s, n;
    s64_t o, dv;
    it = noise_item(KIND_QUERY);
    n = sphere_cnt > NSLOT ? NSLOT : sphere_cnt;
    s = $urandom_range(0, n - 1);
    for (int k = 0; k < 3; k++) begin
      o = tab_cen[s][k] + $urandom_range(0, 40 * U) - 20 * U;
      dv = tab_cen[s][k] - o + $urandom_range(0, 2 * U) - U;
      case ($urandom_range(0, 2))
        0: dv = dv >>> 2;
        1: dv = dv <<< 1;
        default: ;
      endcase
      it.pos[k] = o[31:0];
      it.dir[k] = dv[31:0];
    end
    case ($urandom_range(0, 2))
      0: it.tmin = 0;
      1: it.tmin = -U;
      default: it.tmin = $urandom_range(0, U / 2);
    endcase
    it.tmax = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4 * U) : 32'sh7FFFFFFF;
    return it;
  endfunction

  initial begin
    int cnt, phase_no;
    item_t it;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    words_sent = 0;
    quiet = 0;
    hold_req = 0;
    sphere_cnt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      for (int k = 0; k < 3; k++) tab_cen[i][k] = 0;
      tab_rad[i] = 0;
      tab_mat[i] = 0;
    end

    // count is zero after reset: always a miss
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, U, 0, 0, 0, 32'h7FFFFFFF), 0, 1);
    add_step(ST_LOAD, mk(KIND_LOAD, 0, 0, 0, 5 * U, 0, 0, 0, U, 7, 0, 0), 0, 0);
    add_step(ST_LOAD, mk(KIND_LOAD, 1, 0, 0, 10 * U, 0, 0, 0, 2 * U, 200, 0, 0), 0, 0);
    // zero radius never hit, even right in front of the ray
    add_step(ST_LOAD, mk(KIND_LOAD, 2, 0, 0, 3 * U, 0, 0, 0, 0, 9, 0, 0), 0, 0);
    add_step(ST_LOAD, mk(KIND_LOAD, 3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                         32'h7FFFFFFF, 255, 0, 0), 0, 0);
    add_step(ST_LOAD, mk(KIND_LOAD, 63, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
                         1, 0, 0, 0), 0, 0);
    add_step(ST_CFG, it, 3, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, U, 0, 0, 0, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF), 0, 1);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, U, 0, 0, 10 * U, U), 0, 1);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, U, 0, 0, 4 * U, 4 * U), 0, 1);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 5 * U, 0, 0, U, 0, 0, 0, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, -U, 0, 0, 0, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, U, 0, 0, 0, 0, 0, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 20 * U, 0, 0, -3 * U, 0, 0, 0, 5 * U), 0, 0);
    add_step(ST_CFG, it, 4, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,
                          32'h80000000, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h80000000, 0, 0,
                          32'h80000000, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 0, 0, 0, 1, 1, 1, 0, 0, -U, 32'h7FFFFFFF), 0, 0);
    add_step(ST_QUERY, mk(KIND_QUERY, 0, 32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000, -U, -U,
                          -U, 0, 0, 0, 32'h7FFFFFFF), 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].op == ST_CFG) cfg_write(steps[i].cfg);
      else send(steps[i].it, steps[i].known_miss);
    end

    // fill every slot, then the largest settings
    for (int i = 0; i < NSLOT; i++)
      send($urandom_range(0, 9) == 0 ? noise_item(KIND_LOAD) : good_sphere(i), 0);
    for (int i = 0; i < NSLOT; i++) send(good_sphere(i), 0);
    cfg_write(7'd64);
    repeat (3) send(aimed_ray(), 0);
    cfg_write(7'd127);
    repeat (2) send(aimed_ray(), 0);

    phase_no = 0;
    while (words_sent < TARGET_WORDS) begin
      phase_no++;
      quiet = words_sent > TARGET_WORDS - 200;
      cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      cfg_write(cnt[6:0]);
      if (phase_no == 3) hold_req = 1;
      for (int j = 0; j < 60; j++) begin
        if ($urandom_range(0, 4) < 2) begin
          it = ($urandom_range(0, 9) == 0) ? noise_item(KIND_LOAD)
                                           : good_sphere($urandom_range(0, NSLOT - 1));
          it.kind = KIND_LOAD;
        end else begin
          it = (cnt > 0 && $urandom_range(0, 19) > 2) ? aimed_ray() : noise_item(KIND_QUERY);
        end
        send(it, 0);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rsch_pkg.sv
src/rsch_table.sv
src/rsch_mathu.sv
src/ray_sphere_closest_hit_core.sv
verif/ray_sphere_closest_hit_core_tb.sv
